// ===== hw/rtl/lrc_pkg.sv =====
`timescale 1ns / 1ps
package lrc_pkg;
   localparam int KEY_W               = 31;
   localparam int SLOT_OUT_W          = 4;
   localparam int CAP_W               = 5;
   localparam int MAX_ENTRIES_DEFAULT = 16;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;
endpackage

// ===== hw/rtl/lrc_cell.sv =====
`timescale 1ns / 1ps
module lrc_cell #(
   parameter int MAX_ENTRIES = lrc_pkg::MAX_ENTRIES_DEFAULT,
   parameter int INDEX       = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [lrc_pkg::KEY_W-1:0]    probe_key,
   input  logic [$clog2(MAX_ENTRIES)-1:0] vict_rank,
   input  logic [3*$clog2(MAX_ENTRIES)+lrc_pkg::KEY_W+3+$clog2(MAX_ENTRIES)-1:0] tok_in,
   output logic [3*$clog2(MAX_ENTRIES)+lrc_pkg::KEY_W+3+$clog2(MAX_ENTRIES)-1:0] tok_out,
   input  logic [2*$clog2(MAX_ENTRIES)+2:0] upd_in
);
   localparam int SW = $clog2(MAX_ENTRIES);
   localparam logic [SW-1:0] MY_SLOT = SW'(INDEX);

   typedef struct packed {
      logic                      hit;
      logic [SW-1:0]             hit_slot;
      logic [SW-1:0]             hit_rank;
      logic                      free;
      logic [SW-1:0]             free_slot;
      logic                      vict;
      logic [SW-1:0]             vict_slot;
      logic [lrc_pkg::KEY_W-1:0] vict_key;
   } tok_type;

   typedef struct packed {
      logic          en;
      logic          age_all;
      logic          write_key;
      logic [SW-1:0] slot;
      logic [SW-1:0] limit;
   } upd_type;

   tok_type tin, tok_in_w, tok_ff;
   upd_type upd;

   logic [lrc_pkg::KEY_W-1:0] key_ff, key_in;
   logic                      valid_ff, valid_in;
   logic [SW-1:0]             rank_ff, rank_in;
   logic                      match;

   assign tin     = tok_in;
   assign upd     = upd_in;
   assign tok_out = tok_ff;
   assign match   = valid_ff && (key_ff == probe_key);

   always_comb begin
      tok_in_w = tin;
      if (match && !tin.hit) begin
         tok_in_w.hit      = 1'b1;
         tok_in_w.hit_slot = MY_SLOT;
         tok_in_w.hit_rank = rank_ff;
      end
      if (!valid_ff && !tin.free) begin
         tok_in_w.free      = 1'b1;
         tok_in_w.free_slot = MY_SLOT;
      end
      if (valid_ff && rank_ff == vict_rank && !tin.vict) begin
         tok_in_w.vict      = 1'b1;
         tok_in_w.vict_slot = MY_SLOT;
         tok_in_w.vict_key  = key_ff;
      end
   end

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (upd.en) begin
         if (upd.slot == MY_SLOT) begin
            rank_in  = '0;
            valid_in = 1'b1;
            if (upd.write_key) begin
               key_in = probe_key;
            end
         end else if (valid_ff && (upd.age_all || rank_ff < upd.limit)) begin
            rank_in = rank_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tok_ff <= tok_in_w;
   end
endmodule

// ===== hw/rtl/lrc_ctrl.sv =====
`timescale 1ns / 1ps
module lrc_ctrl #(
   parameter int MAX_ENTRIES = lrc_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [lrc_pkg::KEY_W-1:0]         req_row_key,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [lrc_pkg::SLOT_OUT_W-1:0]    rsp_slot,
   output logic                              rsp_fetch_needed,
   output logic                              rsp_evicted,
   output logic [lrc_pkg::KEY_W-1:0]         rsp_evicted_key,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lrc_pkg::CAP_W-1:0]         csr_capacity,
   output logic [lrc_pkg::KEY_W-1:0]         probe_key,
   output logic [$clog2(MAX_ENTRIES)-1:0]    vict_rank,
   input  logic [3*$clog2(MAX_ENTRIES)+lrc_pkg::KEY_W+3+$clog2(MAX_ENTRIES)-1:0] tok_end,
   output logic [2*$clog2(MAX_ENTRIES)+2:0]  upd_out
);
   localparam int SW = $clog2(MAX_ENTRIES);
   localparam int OW = $clog2(MAX_ENTRIES + 1);
   localparam int CW = (OW > lrc_pkg::CAP_W) ? OW : lrc_pkg::CAP_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   typedef struct packed {
      logic                      hit;
      logic [SW-1:0]             hit_slot;
      logic [SW-1:0]             hit_rank;
      logic                      free;
      logic [SW-1:0]             free_slot;
      logic                      vict;
      logic [SW-1:0]             vict_slot;
      logic [lrc_pkg::KEY_W-1:0] vict_key;
   } tok_type;

   typedef struct packed {
      logic          en;
      logic          age_all;
      logic          write_key;
      logic [SW-1:0] slot;
      logic [SW-1:0] limit;
   } upd_type;

   tok_type tok;
   upd_type upd;

   logic [1:0]                state_ff, state_in;
   logic [SW-1:0]             cnt_ff, cnt_in;
   logic                      act_ff;
   logic [lrc_pkg::KEY_W-1:0] key_ff;
   logic [OW-1:0]             occ_ff, occ_in;
   logic [lrc_pkg::CAP_W-1:0] cap_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         hit_ff, fetch_ff, evicted_ff;
   logic [lrc_pkg::SLOT_OUT_W-1:0] slot_ff;
   logic [lrc_pkg::KEY_W-1:0]    ev_key_ff;

   logic [CW-1:0] cap_ext, cap_eff;
   logic          full, miss, do_evict, do_alloc, fire, accept;

   assign tok       = tok_end;
   assign upd_out   = upd;
   assign probe_key = key_ff;
   assign vict_rank = SW'(occ_ff - OW'(1));

   assign req_ready        = (state_ff == ST_IDLE);
   assign accept           = req_valid && req_ready;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_fetch_needed = fetch_ff;
   assign rsp_evicted      = evicted_ff;
   assign rsp_evicted_key  = ev_key_ff;

   // capacity 0 acts as 1, above the table size as the table size
   always_comb begin
      cap_ext = CW'(cap_ff);
      if (cap_ext == '0) begin
         cap_eff = CW'(1);
      end else if (cap_ext > CW'(MAX_ENTRIES)) begin
         cap_eff = CW'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign full     = CW'(occ_ff) >= cap_eff;
   assign miss     = !tok.hit;
   assign do_evict = miss && full;
   assign do_alloc = miss && !full;
   assign fire     = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      upd.en        = fire;
      upd.age_all   = do_alloc;
      upd.write_key = miss;
      if (tok.hit) begin
         upd.slot  = tok.hit_slot;
         upd.limit = tok.hit_rank;
      end else if (do_evict) begin
         upd.slot  = tok.vict_slot;
         upd.limit = vict_rank;
      end else begin
         upd.slot  = tok.free_slot;
         upd.limit = vict_rank;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == SW'(MAX_ENTRIES - 1)) begin
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff + SW'(1);
            end
         end
         ST_UPDATE: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (do_alloc) begin
                  occ_in = occ_ff + OW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         occ_ff       <= '0;
         cap_ff       <= lrc_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         key_ff <= req_row_key;
      end
      if (fire) begin
         hit_ff     <= tok.hit;
         slot_ff    <= lrc_pkg::SLOT_OUT_W'(upd.slot);
         fetch_ff   <= miss && (act_ff == lrc_pkg::ACT_READ);
         evicted_ff <= do_evict;
         ev_key_ff  <= do_evict ? tok.vict_key : '0;
      end
   end

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised without an update");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(occ_ff) <= CW'(MAX_ENTRIES))
      else $error("occupancy above table size");

   a_free_on_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && do_alloc) |-> tok.free)
      else $error("allocation without a free entry");

   a_vict_on_evict: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && do_evict) |-> tok.vict)
      else $error("eviction without a victim");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(hit_ff && (evicted_ff || fetch_ff)))
      else $error("hit word reports eviction or fetch");
endmodule

// ===== hw/rtl/lru_row_cache_controller.sv =====
`timescale 1ns / 1ps
// Fully associative row cache tag controller, LRU replacement, write-back.
// req channel: req_action (0 read, 1 write) and req_row_key, one word per
//   request. rsp channel: one word per request with hit, slot, fetch_needed,
//   evicted and evicted_key, in request order.
// csr channel: csr_capacity sets how many entries fill before eviction;
//   write it only while no request is in flight.
// The tag store is a chain of MAX_ENTRIES cells. A probe word walks the chain
//   one cell per cycle, collecting the hit, the lowest free entry and the LRU
//   entry; then the update state writes all cells at once.
// A new request is taken only after the previous one has finished its walk and update.
// A finished response is held in an output register; the next request is
//   taken while it waits. If rsp_ready stays low, the following request
//   stalls in its update state until the register frees.
// Reset: all entries invalid, occupancy zero, capacity 16. No clearing pass.
module lru_row_cache_controller #(
   parameter int MAX_ENTRIES = lrc_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [lrc_pkg::KEY_W-1:0]      req_row_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_hit,
   output logic [lrc_pkg::SLOT_OUT_W-1:0] rsp_slot,
   output logic                           rsp_fetch_needed,
   output logic                           rsp_evicted,
   output logic [lrc_pkg::KEY_W-1:0]      rsp_evicted_key,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lrc_pkg::CAP_W-1:0]      csr_capacity
);
   localparam int SW    = $clog2(MAX_ENTRIES);
   localparam int TOK_W = 4*SW + lrc_pkg::KEY_W + 3;
   localparam int UPD_W = 2*SW + 3;

   logic [TOK_W-1:0]          tok_bus [0:MAX_ENTRIES];
   logic [UPD_W-1:0]          upd;
   logic [lrc_pkg::KEY_W-1:0] probe_key;
   logic [SW-1:0]             vict_rank;

   assign tok_bus[0] = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      lrc_cell #(
         .MAX_ENTRIES(MAX_ENTRIES),
         .INDEX      (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .probe_key(probe_key),
         .vict_rank(vict_rank),
         .tok_in   (tok_bus[i]),
         .tok_out  (tok_bus[i+1]),
         .upd_in   (upd)
      );
   end

   lrc_ctrl #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_row_key     (req_row_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_fetch_needed(rsp_fetch_needed),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity),
      .probe_key       (probe_key),
      .vict_rank       (vict_rank),
      .tok_end         (tok_bus[MAX_ENTRIES]),
      .upd_out         (upd)
   );
endmodule
